FILE: rtl/core/sst_pkg.sv
// Package: token kinds, error codes, scan modes and result types of the source tokenizer.
`default_nettype none
package sst_pkg;
  localparam int MaxRes = 8;

  localparam logic [5:0] K_NEWLINE = 6'd0, K_QUESTION = 6'd1, K_COLON = 6'd2, K_EQ_EQ = 6'd3,
    K_EQ = 6'd4, K_PLUS_EQ = 6'd5, K_PLUS_PLUS = 6'd6, K_PLUS = 6'd7, K_MINUS_EQ = 6'd8,
    K_MINUS_MINUS = 6'd9, K_MINUS = 6'd10, K_STAR_EQ = 6'd11, K_STAR_STAR_EQ = 6'd12,
    K_STAR_STAR = 6'd13, K_STAR = 6'd14, K_SLASH_EQ = 6'd15, K_SLASH = 6'd16,
    K_PERCENT_EQ = 6'd17, K_PERCENT = 6'd18, K_SHL_EQ = 6'd19, K_SHL = 6'd20, K_LE = 6'd21,
    K_LT = 6'd22, K_SHR_EQ = 6'd23, K_SHR = 6'd24, K_GE = 6'd25, K_GT = 6'd26, K_NE = 6'd27,
    K_NOT = 6'd28, K_TILDE = 6'd29, K_AND_AND = 6'd30, K_AND_EQ = 6'd31, K_AND = 6'd32,
    K_OR_OR = 6'd33, K_OR_EQ = 6'd34, K_OR = 6'd35, K_XOR_EQ = 6'd36, K_XOR = 6'd37,
    K_ELLIPSIS = 6'd38, K_DOT = 6'd39, K_COMMA = 6'd40, K_SEMI = 6'd41, K_HASH_HASH = 6'd42,
    K_HASH_EQ = 6'd43, K_HASH_NE = 6'd44, K_LPAREN = 6'd45, K_RPAREN = 6'd46,
    K_LBRACKET = 6'd47, K_RBRACKET = 6'd48, K_LBRACE = 6'd49, K_RBRACE = 6'd50,
    K_STRING = 6'd51, K_CHAR = 6'd52, K_WORD = 6'd53, K_INTEGER = 6'd54, K_REAL = 6'd55,
    K_END = 6'd56, K_ERROR = 6'd57;

  localparam logic [2:0] E_NONE = 3'd0, E_COMMENT = 3'd1, E_ESCAPE = 3'd2, E_STRING = 3'd3,
    E_CHAR = 3'd4, E_QUOTE = 3'd5, E_REAL = 3'd6, E_UNEXPECTED = 3'd7;

  typedef enum logic [12:0] {
    M_DEFAULT    = 13'h0001,
    M_SKIP1      = 13'h0002,
    M_SKIP2      = 13'h0004,
    M_LINE       = 13'h0008,
    M_BLOCK      = 13'h0010,
    M_STRING     = 13'h0020,
    M_STR_ESC    = 13'h0040,
    M_CHAR_A     = 13'h0080,
    M_CHAR_ESC   = 13'h0100,
    M_CHAR_CLOSE = 13'h0200,
    M_WORD       = 13'h0400,
    M_HASH_WORD  = 13'h0800,
    M_NUMBER     = 13'h1000
  } mode_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] lexeme;
    logic       valid;
    logic       last;
    logic       hash;
    logic [2:0] err;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [3:0]        n;
  } rlist_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] prev;
    logic       seen_point;
    logic       quote_pending;
    logic [7:0] lit;
  } scan_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] len;
    logic [5:0] kind;
  } op_t;
endpackage
`default_nettype wire

FILE: rtl/core/script_source_tokenizer.sv
// Top level: streaming tokenizer, one source byte in, token result bytes out.
//
// Input channel s_*: s_tdata[7:0] carries the source byte, s_tuser[0] the kind
// (0 = byte, 1 = end of source). Output channel m_*: one token result per
// transaction, m_tlast marks the last result of a token.
// Each accepted input is scanned in the cycle it is accepted; its results are
// stored in an 8-entry result register and shown from the next cycle, one per
// cycle while the receiver is ready. An input that gives several results
// holds s_tready low until the single output port has drained the result
// register down to its last result. While the receiver is ready and each
// input gives at most one result, an input is taken every cycle.
// The first two source bytes only fill the lookahead and give no result.
// When the receiver stalls, the pending result holds and s_tready stays low
// until the last pending result is taken (it may be taken in the same cycle).
// Reset (rst, synchronous) clears the scan state, lookahead and pending result count.
// After end of source the scan state returns to reset and a new source may follow.
`default_nettype none
module script_source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] source_byte
  input  wire logic [0:0]  s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] lexeme_byte, [10:8] error_code, [11] run_last
  output logic [7:0]       m_tuser,   // [5:0] token_kind, [6] byte_valid, [7] hash_prefix
  output logic             m_tlast    // token_last
);
  import sst_pkg::*;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction
  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction
  function automatic logic is_word(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == 8'h5F;
  endfunction
  function automatic logic is_num(logic [7:0] c);
    return is_digit(c) || c == 8'h2E || c == 8'h27;
  endfunction

  function automatic res_t mk(logic [5:0] k, logic [7:0] b, logic v, logic l, logic h,
                              logic [2:0] e);
    res_t x;
    x.kind = k; x.lexeme = b; x.valid = v; x.last = l; x.hash = h; x.err = e;
    return x;
  endfunction

  function automatic void emit(inout rlist_t l, input res_t x);
    if (l.n < 4'(MaxRes)) begin
      l.r[l.n[2:0]] = x;
      l.n = l.n + 4'd1;
    end
  endfunction

  // {ok, value}
  function automatic logic [8:0] decode_escape(logic [7:0] c);
    logic [8:0] d;
    unique case (c)
      8'h6E:   d = {1'b1, 8'h0A};
      8'h72:   d = {1'b1, 8'h0D};
      8'h74:   d = {1'b1, 8'h09};
      8'h27:   d = {1'b1, 8'h27};
      8'h22:   d = {1'b1, 8'h22};
      8'h5C:   d = {1'b1, 8'h5C};
      8'h30:   d = {1'b1, 8'h00};
      default: d = {1'b0, 8'h5C};
    endcase
    return d;
  endfunction

  function automatic op_t op2(logic [5:0] k2, logic m2, logic [5:0] k1);
    op_t o;
    o.hit = 1'b1;
    o.len = m2 ? 2'd2 : 2'd1;
    o.kind = m2 ? k2 : k1;
    return o;
  endfunction

  function automatic op_t op_match(logic [7:0] ch, logic [7:0] p1, logic [7:0] p2);
    op_t o;
    o = op2(K_NEWLINE, 1'b0, K_NEWLINE);
    unique case (ch)
      8'h0A: o = op2(K_NEWLINE, 1'b0, K_NEWLINE);
      8'h3F: o = op2(K_QUESTION, 1'b0, K_QUESTION);
      8'h3A: o = op2(K_COLON, 1'b0, K_COLON);
      8'h3D: o = op2(K_EQ_EQ, p1 == 8'h3D, K_EQ);
      8'h2B: o = (p1 == 8'h3D) ? op2(K_PLUS_EQ, 1'b1, K_PLUS)
                               : op2(K_PLUS_PLUS, p1 == 8'h2B, K_PLUS);
      8'h2D: o = (p1 == 8'h3D) ? op2(K_MINUS_EQ, 1'b1, K_MINUS)
                               : op2(K_MINUS_MINUS, p1 == 8'h2D, K_MINUS);
      8'h2A: begin
        if (p1 == 8'h3D) o = op2(K_STAR_EQ, 1'b1, K_STAR);
        else if (p1 == 8'h2A && p2 == 8'h3D) o = '{1'b1, 2'd3, K_STAR_STAR_EQ};
        else o = op2(K_STAR_STAR, p1 == 8'h2A, K_STAR);
      end
      8'h2F: o = op2(K_SLASH_EQ, p1 == 8'h3D, K_SLASH);
      8'h25: o = op2(K_PERCENT_EQ, p1 == 8'h3D, K_PERCENT);
      8'h3C: begin
        if (p1 == 8'h3C && p2 == 8'h3D) o = '{1'b1, 2'd3, K_SHL_EQ};
        else if (p1 == 8'h3C) o = op2(K_SHL, 1'b1, K_LT);
        else o = op2(K_LE, p1 == 8'h3D, K_LT);
      end
      8'h3E: begin
        if (p1 == 8'h3E && p2 == 8'h3D) o = '{1'b1, 2'd3, K_SHR_EQ};
        else if (p1 == 8'h3E) o = op2(K_SHR, 1'b1, K_GT);
        else o = op2(K_GE, p1 == 8'h3D, K_GT);
      end
      8'h21: o = op2(K_NE, p1 == 8'h3D, K_NOT);
      8'h7E: o = op2(K_TILDE, 1'b0, K_TILDE);
      8'h26: o = (p1 == 8'h26) ? op2(K_AND_AND, 1'b1, K_AND)
                               : op2(K_AND_EQ, p1 == 8'h3D, K_AND);
      8'h7C: o = (p1 == 8'h7C) ? op2(K_OR_OR, 1'b1, K_OR)
                               : op2(K_OR_EQ, p1 == 8'h3D, K_OR);
      8'h5E: o = op2(K_XOR_EQ, p1 == 8'h3D, K_XOR);
      8'h2E: o = (p1 == 8'h2E && p2 == 8'h2E) ? op_t'{1'b1, 2'd3, K_ELLIPSIS}
                                              : op2(K_DOT, 1'b0, K_DOT);
      8'h2C: o = op2(K_COMMA, 1'b0, K_COMMA);
      8'h3B: o = op2(K_NEWLINE, p1 == 8'h3B, K_SEMI);
      8'h23: begin
        if (p1 == 8'h23) o = op2(K_HASH_HASH, 1'b1, K_HASH_HASH);
        else if (p1 == 8'h3D && p2 == 8'h3D) o = '{1'b1, 2'd3, K_HASH_EQ};
        else if (p1 == 8'h21 && p2 == 8'h3D) o = '{1'b1, 2'd3, K_HASH_NE};
        else o = '{1'b0, 2'd1, K_HASH_HASH};
      end
      8'h28: o = op2(K_LPAREN, 1'b0, K_LPAREN);
      8'h29: o = op2(K_RPAREN, 1'b0, K_RPAREN);
      8'h5B: o = op2(K_LBRACKET, 1'b0, K_LBRACKET);
      8'h5D: o = op2(K_RBRACKET, 1'b0, K_RBRACKET);
      8'h7B: o = op2(K_LBRACE, 1'b0, K_LBRACE);
      8'h7D: o = op2(K_RBRACE, 1'b0, K_RBRACE);
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

  function automatic void number_byte(inout scan_t s, inout rlist_t l,
                                      input logic [7:0] ch, input logic [7:0] p1);
    logic       c;
    logic [5:0] k;
    c = is_num(p1);
    if (ch == 8'h27) begin
      if (s.quote_pending) emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_QUOTE));
      s.quote_pending = 1'b1;
    end else begin
      if (ch == 8'h2E) begin
        if (s.seen_point) emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_REAL));
        s.seen_point = 1'b1;
      end
      s.quote_pending = 1'b0;
    end
    k = s.seen_point ? K_REAL : K_INTEGER;
    if (ch != 8'h27) begin
      emit(l, mk(k, ch, 1'b1, !c, 1'b0, E_NONE));
    end else if (!c) begin
      emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_QUOTE));
      emit(l, mk(k, 8'h00, 1'b0, 1'b1, 1'b0, E_NONE));
    end
    s.mode = c ? M_NUMBER : M_DEFAULT;
  endfunction

  function automatic void default_byte(inout scan_t s, inout rlist_t l, input logic [7:0] ch,
                                       input logic [7:0] p1, input logic [7:0] p2,
                                       input logic av1);
    op_t  o;
    logic c;
    o = op_match(ch, p1, p2);
    c = is_word(p1);
    if (ch == 8'h2F && p1 == 8'h2F) begin
      s.mode = M_LINE;
    end else if (ch == 8'h2F && p1 == 8'h2A) begin
      if (s.prev != 8'h2A) s.mode = M_BLOCK;
    end else if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0B || ch == 8'h0C || ch == 8'h0D) begin
      s.mode = M_DEFAULT;
    end else if (o.hit) begin
      emit(l, mk(o.kind, ch, 1'b1, o.len == 2'd1, 1'b0, E_NONE));
      if (o.len != 2'd1) emit(l, mk(o.kind, p1, 1'b1, o.len == 2'd2, 1'b0, E_NONE));
      if (o.len == 2'd3) emit(l, mk(o.kind, p2, 1'b1, 1'b1, 1'b0, E_NONE));
      s.mode = (o.len == 2'd3) ? M_SKIP2 : ((o.len == 2'd2) ? M_SKIP1 : M_DEFAULT);
    end else if (ch == 8'h22) begin
      if (!av1) begin
        emit(l, mk(K_STRING, 8'h00, 1'b0, 1'b1, 1'b0, E_NONE));
      end else begin
        if (p1 == 8'h22) emit(l, mk(K_STRING, 8'h00, 1'b0, 1'b1, 1'b0, E_NONE));
        s.mode = M_STRING;
      end
    end else if (ch == 8'h27) begin
      s.mode = M_CHAR_A;
    end else if (ch == 8'h23) begin
      if (c) s.mode = M_HASH_WORD;
      else emit(l, mk(K_WORD, 8'h00, 1'b0, 1'b1, 1'b1, E_NONE));
    end else if (is_alpha(ch) || ch == 8'h5F) begin
      emit(l, mk(K_WORD, ch, 1'b1, !c, 1'b0, E_NONE));
      if (c) s.mode = M_WORD;
    end else if (is_digit(ch)) begin
      s.seen_point = 1'b0;
      s.quote_pending = 1'b0;
      number_byte(s, l, ch, p1);
    end else begin
      emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_UNEXPECTED));
    end
  endfunction

  function automatic void scan_byte(inout scan_t s, inout rlist_t l, input logic [7:0] ch,
                                    input logic [7:0] p1, input logic [7:0] p2,
                                    input logic av1);
    logic [8:0] d;
    d = decode_escape(ch);
    unique case (s.mode)
      M_SKIP2: s.mode = M_SKIP1;
      M_SKIP1: s.mode = M_DEFAULT;
      M_LINE:  if (ch == 8'h0A) s.mode = M_DEFAULT;
      M_BLOCK: if (s.prev == 8'h2A && ch == 8'h2F) s.mode = M_DEFAULT;
      M_STRING: begin
        if (ch == 8'h22) s.mode = M_DEFAULT;
        else if (ch == 8'h5C) s.mode = M_STR_ESC;
        else emit(l, mk(K_STRING, ch, 1'b1, p1 == 8'h22, 1'b0, E_NONE));
      end
      M_STR_ESC: begin
        if (!d[8]) emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_ESCAPE));
        emit(l, mk(K_STRING, d[7:0], 1'b1, p1 == 8'h22, 1'b0, E_NONE));
        s.mode = M_STRING;
      end
      M_CHAR_A: begin
        if (ch == 8'h5C) s.mode = M_CHAR_ESC;
        else begin
          s.lit = ch;
          s.mode = M_CHAR_CLOSE;
        end
      end
      M_CHAR_ESC: begin
        if (!d[8]) emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_ESCAPE));
        s.lit = d[7:0];
        s.mode = M_CHAR_CLOSE;
      end
      M_CHAR_CLOSE: begin
        if (ch != 8'h27) emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_CHAR));
        emit(l, mk(K_CHAR, s.lit, 1'b1, 1'b1, 1'b0, E_NONE));
        s.mode = M_DEFAULT;
      end
      M_WORD, M_HASH_WORD: begin
        emit(l, mk(K_WORD, ch, 1'b1, !is_word(p1), s.mode == M_HASH_WORD, E_NONE));
        if (!is_word(p1)) s.mode = M_DEFAULT;
      end
      M_NUMBER: number_byte(s, l, ch, p1);
      default: begin
        s.mode = M_DEFAULT;
        default_byte(s, l, ch, p1, p2, av1);
      end
    endcase
    s.prev = ch;
  endfunction

  localparam scan_t ScanReset = '{M_DEFAULT, 8'h00, 1'b0, 1'b0, 8'h00};

  scan_t      st, st_next;
  logic [7:0] held0, held1, held0_next, held1_next;
  logic [1:0] held_count, held_count_next;
  rlist_t     list_next;
  res_t [MaxRes-1:0] results;
  logic [2:0] idx;
  logic [3:0] cnt;
  logic       in_fire, out_fire;
  res_t       cur;

  always_comb begin
    scan_t  s;
    rlist_t l;
    logic   ab;
    s = st;
    l = '0;
    ab = 1'b0;
    held0_next = held0;
    held1_next = held1;
    held_count_next = held_count;
    if (s_tuser[0] == 1'b0) begin
      if (held_count < 2'd2) begin
        if (held_count == 2'd0) held0_next = s_tdata;
        else held1_next = s_tdata;
        held_count_next = held_count + 2'd1;
      end else begin
        scan_byte(s, l, held0, held1, s_tdata, 1'b1);
        held0_next = held1;
        held1_next = s_tdata;
      end
    end else begin
      if (held_count >= 2'd2) begin
        scan_byte(s, l, held0, held1, 8'h00, 1'b1);
        scan_byte(s, l, held1, 8'h00, 8'h00, 1'b0);
      end else if (held_count == 2'd1) begin
        scan_byte(s, l, held0, 8'h00, 8'h00, 1'b0);
      end
      unique case (s.mode)
        M_BLOCK: emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_COMMENT));
        M_STRING: begin
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_STRING));
          ab = 1'b1;
        end
        M_STR_ESC: begin
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_ESCAPE));
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_STRING));
          ab = 1'b1;
        end
        M_CHAR_A: begin
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_CHAR));
          emit(l, mk(K_CHAR, 8'h00, 1'b1, 1'b1, 1'b0, E_NONE));
        end
        M_CHAR_ESC: begin
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_ESCAPE));
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_CHAR));
          emit(l, mk(K_CHAR, 8'h5C, 1'b1, 1'b1, 1'b0, E_NONE));
        end
        M_CHAR_CLOSE: begin
          emit(l, mk(K_ERROR, 8'h00, 1'b0, 1'b0, 1'b0, E_CHAR));
          emit(l, mk(K_CHAR, s.lit, 1'b1, 1'b1, 1'b0, E_NONE));
        end
        default: ab = 1'b0;
      endcase
      if (!ab) begin
        emit(l, mk(K_END, 8'h45, 1'b1, 1'b0, 1'b0, E_NONE));
        emit(l, mk(K_END, 8'h4F, 1'b1, 1'b0, 1'b0, E_NONE));
        emit(l, mk(K_END, 8'h46, 1'b1, 1'b1, 1'b0, E_NONE));
      end
      s = ScanReset;
      held0_next = 8'h00;
      held1_next = 8'h00;
      held_count_next = 2'd0;
    end
    st_next = s;
    list_next = l;
  end

  assign m_tvalid = cnt != 4'd0;
  assign s_tready = (cnt == 4'd0) || (cnt == 4'd1 && m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign cur      = results[idx];
  assign m_tdata  = {4'd0, cnt == 4'd1, cur.err, cur.lexeme};
  assign m_tuser  = {cur.hash, cur.valid, cur.kind};
  assign m_tlast  = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ScanReset;
      held0 <= 8'h00;
      held1 <= 8'h00;
      held_count <= 2'd0;
      cnt <= 4'd0;
      idx <= 3'd0;
    end else if (in_fire) begin
      st <= st_next;
      held0 <= held0_next;
      held1 <= held1_next;
      held_count <= held_count_next;
      cnt <= list_next.n;
      idx <= 3'd0;
    end else if (out_fire) begin
      cnt <= cnt - 4'd1;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) results <= list_next.r;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 4'(MaxRes))
    else $error("result count exceeds buffer depth");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("idle block not ready for input");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_fire && list_next.n != 4'd0 |=> m_tvalid && idx == 3'd0)
    else $error("results of accepted transaction not shown");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_fire && !in_fire |=> cnt == $past(cnt) - 4'd1)
    else $error("drain count slip");
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && held_count == 2'd0)
    else $error("reset did not clear block");
endmodule
`default_nettype wire
